// File: hw/rtl/round_robin_task_picker_unit_assert.svh
// assertion helpers shared by the task picker rtl
`ifndef ROUND_ROBIN_TASK_PICKER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_PICKER_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define RRTP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define RRTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rrtp_pkg.sv
`timescale 1ns / 1ps

package rrtp_pkg;

  localparam int NTASKS_DEF    = 16;
  localparam int TICK_BITS_DEF = 32;

  typedef enum logic [2:0] {
    TS_NEW     = 3'd0,
    TS_READY   = 3'd1,
    TS_BLOCKED = 3'd2,
    TS_TIMED   = 3'd3,
    TS_SLEEP   = 3'd4,
    TS_TERM    = 3'd5
  } task_state_e;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_SCHED = 1'b1
  } item_kind_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_WBACK,
    FSM_FINISH
  } fsm_e;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic        slot_used;
    logic [2:0]  task_state;
    logic        task_suspended;
    logic [31:0] wake_tick;
    logic [31:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [3:0] picked_slot;
    logic       timed_out;
    logic [4:0] freed_count;
  } out_item_t;

  // slot table control
  typedef struct packed {
    logic we;
    logic wvalid;
    logic re;
    logic clr;
  } tbl_ctl_t;

  typedef struct packed {
    logic [2:0] state;
    logic       susp;
  } slot_attr_t;

endpackage

// File: hw/rtl/rrtp_tick_cmp.sv
`timescale 1ns / 1ps

module rrtp_tick_cmp #(
  parameter int TICK_BITS = 32
) (
  input  logic [TICK_BITS-1:0] wake_i,
  input  logic [TICK_BITS-1:0] now_i,
  output logic                 ahead_o
);

  logic [TICK_BITS-1:0] diff;

  // wake is ahead when the wrapped difference is nonzero and positive
  assign diff    = wake_i - now_i;
  assign ahead_o = (diff != '0) && !diff[TICK_BITS-1];

endmodule

// File: hw/rtl/rrtp_table.sv
`timescale 1ns / 1ps

module rrtp_table #(
  parameter int NTASKS    = 16,
  parameter int TICK_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rrtp_pkg::tbl_ctl_t         ctl_i,
  input  logic [$clog2(NTASKS)-1:0]  waddr_i,
  input  rrtp_pkg::slot_attr_t       wattr_i,
  input  logic [TICK_BITS-1:0]       wwake_i,
  input  logic [$clog2(NTASKS)-1:0]  raddr_i,
  input  logic [$clog2(NTASKS)-1:0]  cidx_i,
  output logic                       rvalid_o,
  output rrtp_pkg::slot_attr_t       rattr_o,
  output logic [TICK_BITS-1:0]       rwake_o
);

  import rrtp_pkg::*;

  logic [NTASKS-1:0]    valid_q;
  logic                 rvalid_q;
  slot_attr_t           attr_mem [NTASKS];
  logic [TICK_BITS-1:0] wake_mem [NTASKS];
  slot_attr_t           rattr_q;
  logic [TICK_BITS-1:0] rwake_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        valid_q[waddr_i] <= ctl_i.wvalid;
      end else if (ctl_i.clr) begin
        valid_q[cidx_i] <= 1'b0;
      end
      if (ctl_i.re) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      attr_mem[waddr_i] <= wattr_i;
      wake_mem[waddr_i] <= wwake_i;
    end
    if (ctl_i.re) begin
      rattr_q <= attr_mem[raddr_i];
      rwake_q <= wake_mem[raddr_i];
    end
  end

  assign rvalid_o = rvalid_q;
  assign rattr_o  = rattr_q;
  assign rwake_o  = rwake_q;

endmodule

// File: hw/rtl/round_robin_task_picker_unit.sv
`timescale 1ns / 1ps
`include "round_robin_task_picker_unit_assert.svh"
// round-robin task picker over a table of NTASKS task slots
// input channel: in_valid_i / in_stall_o / in_data_i. kind selects a slot
// write (slot, slot_used, task_state, task_suspended, wake_tick) or a
// schedule item (now_tick). every item gives exactly one result item on
// out_valid_o / out_stall_i / out_data_o.
// a write item goes straight from acceptance to the finish state. a schedule
// item reads one slot from the table memory per cycle, starting after the
// current slot, and a single wrapped tick comparator judges each timed or
// sleeping slot; terminated slots are freed in the same pass. the drain and
// write-back states then empty the read pipeline and write the picked slot
// back, and the finish state loads the output register. one item is in
// flight at a time; in_stall_o is high from acceptance until the result is
// loaded into the output register, so a new item is taken only after the
// previous result has been loaded.
// a result waits in the output register while out_stall_i is high; a new
// item may be accepted meanwhile, and its own result waits until the
// register is taken.
// reset empties every slot and sets the current slot to zero; no clearing
// pass is needed, the block takes items as soon as reset is released.
module round_robin_task_picker_unit #(
  parameter int NTASKS    = rrtp_pkg::NTASKS_DEF,
  parameter int TICK_BITS = rrtp_pkg::TICK_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rrtp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rrtp_pkg::out_item_t out_data_o
);

  import rrtp_pkg::*;

  localparam int IW = $clog2(NTASKS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NTASKS - 1);

  typedef logic [TICK_BITS-1:0] tick_t;

  fsm_e        state_q, state_d;
  logic [IW-1:0] cur_q, ptr_q, iss_q, e_idx_q, pick_q;
  logic        e_vld_q, found_q, tmo_q, wb_q;
  logic [4:0]  freed_q;
  tick_t       now_q, pick_wake_q;
  logic        out_valid_q;
  out_item_t   out_q;

  tbl_ctl_t    tbl_ctl;
  logic [IW-1:0] tbl_waddr;
  slot_attr_t  tbl_wattr;
  tick_t       tbl_wwake;
  logic        rvalid;
  slot_attr_t  rattr;
  tick_t       rwake;
  logic        ahead;

  logic        accept, load_out, in_range;
  logic        free_hit, pick_hit;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  rrtp_table #(
    .NTASKS   (NTASKS),
    .TICK_BITS(TICK_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (tbl_ctl),
    .waddr_i (tbl_waddr),
    .wattr_i (tbl_wattr),
    .wwake_i (tbl_wwake),
    .raddr_i (ptr_q),
    .cidx_i  (e_idx_q),
    .rvalid_o(rvalid),
    .rattr_o (rattr),
    .rwake_o (rwake)
  );

  rrtp_tick_cmp #(
    .TICK_BITS(TICK_BITS)
  ) u_cmp (
    .wake_i (rwake),
    .now_i  (now_q),
    .ahead_o(ahead)
  );

  assign in_stall_o = (state_q != FSM_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = ({28'd0, in_data_i.slot} < 32'(NTASKS));

  // evaluation of the slot read in the previous cycle
  assign free_hit = e_vld_q && rvalid && (rattr.state == TS_TERM) && (e_idx_q != cur_q);
  assign pick_hit = e_vld_q && rvalid && !rattr.susp &&
                    ((rattr.state == TS_READY) ||
                     (((rattr.state == TS_TIMED) || (rattr.state == TS_SLEEP)) && !ahead));

  always_comb begin
    state_d   = state_q;
    load_out  = 1'b0;
    tbl_ctl   = '0;
    tbl_waddr = IW'(in_data_i.slot);
    tbl_wattr = '{state: in_data_i.task_state, susp: in_data_i.task_suspended};
    tbl_wwake = tick_t'(in_data_i.wake_tick);
    tbl_ctl.wvalid = in_data_i.slot_used;
    tbl_ctl.clr    = free_hit;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if (in_data_i.kind == KIND_WRITE) begin
            tbl_ctl.we = in_range;
            state_d    = FSM_FINISH;
          end else begin
            state_d = FSM_SCAN;
          end
        end
      end
      FSM_SCAN: begin
        tbl_ctl.re = 1'b1;
        if (iss_q == LAST_IDX) begin
          state_d = FSM_DRAIN;
        end
      end
      FSM_DRAIN: begin
        state_d = FSM_WBACK;
      end
      FSM_WBACK: begin
        // picked slot turns ready; a block timeout also drops its wake tick
        tbl_ctl.we     = found_q && wb_q;
        tbl_ctl.wvalid = 1'b1;
        tbl_waddr      = pick_q;
        tbl_wattr      = '{state: TS_READY, susp: 1'b0};
        tbl_wwake      = tmo_q ? '0 : pick_wake_q;
        state_d        = FSM_FINISH;
      end
      FSM_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cur_q       <= '0;
      ptr_q       <= '0;
      iss_q       <= '0;
      e_vld_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      e_vld_q <= (state_q == FSM_SCAN);
      if (accept) begin
        found_q <= 1'b0;
        ptr_q   <= wrap_inc(cur_q);
        iss_q   <= '0;
      end else if (state_q == FSM_SCAN) begin
        ptr_q <= wrap_inc(ptr_q);
        iss_q <= iss_q + 1'b1;
      end
      if (pick_hit && !found_q) begin
        found_q <= 1'b1;
      end
      if (state_q == FSM_WBACK && found_q) begin
        cur_q <= pick_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pick_q  <= '0;
      tmo_q   <= 1'b0;
      wb_q    <= 1'b0;
      freed_q <= '0;
      now_q   <= tick_t'(in_data_i.now_tick);
    end else begin
      e_idx_q <= ptr_q;
      if (free_hit && freed_q != 5'd31) begin
        freed_q <= freed_q + 5'd1;
      end
      if (pick_hit && !found_q) begin
        pick_q      <= e_idx_q;
        tmo_q       <= (rattr.state == TS_TIMED);
        wb_q        <= (rattr.state != TS_READY);
        pick_wake_q <= rwake;
      end
    end
    if (load_out) begin
      out_q <= '{found: found_q, picked_slot: 4'(pick_q), timed_out: tmo_q,
                 freed_count: freed_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RRTP_ASSERT_NEXT(a_scan_len, state_q == FSM_SCAN && iss_q == LAST_IDX, state_q == FSM_DRAIN, "scan pass overran the table")
  `RRTP_ASSERT_SAME(a_tmo_found, state_q == FSM_WBACK && tmo_q, found_q, "timeout flagged without a pick")
  `RRTP_ASSERT_SAME(a_eval_idle, state_q == FSM_IDLE, !e_vld_q, "slot evaluated outside a pass")

endmodule

// File: tb/round_robin_task_picker_unit_tb.sv
`timescale 1ns / 1ps

module round_robin_task_picker_unit_tb;
  import rrtp_pkg::*;

  localparam int NTASKS      = NTASKS_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 840;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  round_robin_task_picker_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // shadow copy of the task table
  logic        tbl_used  [NTASKS];
  logic [2:0]  tbl_state [NTASKS];
  logic        tbl_susp  [NTASKS];
  logic [31:0] tbl_wake  [NTASKS];
  logic [3:0]  cur_slot;

  out_item_t outcome_q[$];
  out_item_t head_outcome;

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned n_writes, n_scheds, n_picks, n_timeouts, n_freed;
  logic        steady_flow;
  logic        hold_req;
  logic [31:0] tick_now;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               outcome_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // result of one item on the shadow table: a write loads a slot, a schedule
  // frees terminated slots and picks the next runnable one
  function automatic out_item_t schedule_outcome(in_item_t it);
    out_item_t   res;
    int unsigned freed;
    int unsigned idx;
    logic [31:0] diff;
    logic [2:0]  st;
    logic        done;
    res = '0;
    freed = 0;
    done = 1'b0;
    if (it.kind == KIND_WRITE) begin
      tbl_used[it.slot]  = it.slot_used;
      tbl_state[it.slot] = it.task_state;
      tbl_susp[it.slot]  = it.task_suspended;
      tbl_wake[it.slot]  = it.wake_tick;
    end else begin
      for (int i = 0; i < NTASKS; i++) begin
        if (tbl_used[i] && tbl_state[i] == TS_TERM && i != cur_slot) begin
          tbl_used[i] = 1'b0;
          freed++;
        end
      end
      res.freed_count = (freed > 31) ? 5'd31 : 5'(freed);
      idx = cur_slot;
      for (int i = 0; i < NTASKS; i++) begin
        idx = (idx + 1) % NTASKS;
        if (!done && tbl_used[idx] && !tbl_susp[idx]) begin
          st = tbl_state[idx];
          diff = tbl_wake[idx] - it.now_tick;
          if (st == TS_READY) begin
            done = 1'b1;
          end else if ((st == TS_TIMED || st == TS_SLEEP) &&
                       !(diff != 0 && !diff[31])) begin
            tbl_state[idx] = TS_READY;
            if (st == TS_TIMED) begin
              tbl_wake[idx] = '0;
              res.timed_out = 1'b1;
            end
            done = 1'b1;
          end
          if (done) begin
            cur_slot = 4'(idx);
            res.found = 1'b1;
            res.picked_slot = 4'(idx);
          end
        end
      end
    end
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    out_item_t   res;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    res = schedule_outcome(it);
    outcome_q.push_back(res);
    if (it.kind == KIND_WRITE) begin
      n_writes++;
    end else begin
      n_scheds++;
      n_picks += res.found;
      n_timeouts += res.timed_out;
      n_freed += res.freed_count;
    end
  endtask

  task automatic write_slot(logic [3:0] slot, logic used, logic [2:0] st, logic susp,
                            logic [31:0] wake);
    in_item_t it;
    it = '0;
    it.kind = KIND_WRITE;
    it.slot = slot;
    it.slot_used = used;
    it.task_state = st;
    it.task_suspended = susp;
    it.wake_tick = wake;
    it.now_tick = $urandom();
    send_item(it);
  endtask

  task automatic schedule_at(logic [31:0] tick);
    in_item_t it;
    it = in_item_t'({$urandom(), $urandom(), $urandom()});
    it.kind = KIND_SCHED;
    it.now_tick = tick;
    send_item(it);
  endtask

  // mostly consistent traffic around a moving tick, some plain noise
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    it = in_item_t'({$urandom(), $urandom(), $urandom()});
    if ($urandom_range(0, 9) == 0) return it;
    if ($urandom_range(0, 99) < 55) begin
      it.kind = KIND_WRITE;
      it.slot_used = ($urandom_range(0, 9) != 0);
      it.task_suspended = ($urandom_range(0, 6) == 0);
      r = $urandom_range(0, 15);
      if (r < 4) it.task_state = TS_READY;
      else if (r < 7) it.task_state = TS_TIMED;
      else if (r < 10) it.task_state = TS_SLEEP;
      else if (r < 12) it.task_state = TS_TERM;
      else if (r == 12) it.task_state = TS_NEW;
      else if (r == 13) it.task_state = TS_BLOCKED;
      else it.task_state = 3'(r - 8);
      case ($urandom_range(0, 3))
        0: it.wake_tick = tick_now + $urandom_range(0, 16);
        1: it.wake_tick = tick_now - $urandom_range(0, 16);
        2: it.wake_tick = tick_now + 32'h8000_0000 - $urandom_range(0, 2);
        default: it.wake_tick = $urandom();
      endcase
    end else begin
      it.kind = KIND_SCHED;
      if ($urandom_range(0, 19) == 0) tick_now = $urandom();
      else tick_now = tick_now + $urandom_range(0, 6);
      it.now_tick = tick_now;
    end
    return it;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result item with none expected, actual %p", $time, out_data_o);
        err_count++;
      end else begin
        head_outcome = outcome_q.pop_front();
        check_field("found", head_outcome.found, out_data_o.found);
        check_field("picked_slot", head_outcome.picked_slot, out_data_o.picked_slot);
        check_field("timed_out", head_outcome.timed_out, out_data_o.timed_out);
        check_field("freed_count", head_outcome.freed_count, out_data_o.freed_count);
      end
    end
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin : receiver_stall
    int unsigned stall_left;
    int unsigned len;
    out_stall_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        len = idle_gap();
        if (len > 0 && $urandom_range(0, 2) == 0) begin
          stall_left = len - 1;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // every slot written empty first, then schedules on an empty table
  task automatic test_empty_table();
    for (int i = 0; i < NTASKS; i++) begin
      write_slot(4'(i), 1'b0, 3'($urandom()), 1'($urandom()), $urandom());
    end
    schedule_at(32'h0);
    schedule_at(32'hFFFF_FFFF);
  endtask

  task automatic test_directed_cases();
    write_slot(4'd0, 1'b1, TS_READY, 1'b0, 32'h0);
    write_slot(4'd15, 1'b1, TS_READY, 1'b0, 32'hFFFF_FFFF);
    schedule_at(32'h0);
    schedule_at(32'h0);
    // timeout one tick early, then exactly on the wake tick
    write_slot(4'd5, 1'b1, TS_TIMED, 1'b0, 32'd100);
    schedule_at(32'd99);
    schedule_at(32'd100);
    schedule_at(32'd100);
    // half-range distance counts as expired, one tick behind wrap does not
    write_slot(4'd7, 1'b1, TS_SLEEP, 1'b0, 32'h8000_0000);
    write_slot(4'd3, 1'b1, TS_SLEEP, 1'b0, 32'h0);
    schedule_at(32'hFFFF_FFFF);
    // states that are never picked
    write_slot(4'd8, 1'b1, TS_READY, 1'b1, 32'h0);
    write_slot(4'd9, 1'b1, TS_NEW, 1'b0, 32'h0);
    write_slot(4'd10, 1'b1, TS_BLOCKED, 1'b0, 32'h0);
    write_slot(4'd11, 1'b1, 3'd6, 1'b0, 32'h0);
    write_slot(4'd12, 1'b1, 3'd7, 1'b0, 32'h0);
    write_slot(4'd13, 1'b1, TS_TERM, 1'b0, 32'h0);
    // the running slot terminates: kept, the other terminated one is freed
    write_slot(cur_slot, 1'b1, TS_TERM, 1'b0, 32'h0);
    schedule_at(32'h1);
    schedule_at(32'h2);
  endtask

  task automatic test_random_traffic();
    tick_now = $urandom();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_flow = (n >= 200 && n < 320);
      send_item(random_item());
    end
    steady_flow = 1'b0;
  endtask

  // output held off for a long stretch while items keep coming
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 12; n++) begin
      send_item(random_item());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    err_count = 0;
    cycle_count = 0;
    n_writes = 0;
    n_scheds = 0;
    n_picks = 0;
    n_timeouts = 0;
    n_freed = 0;
    steady_flow = 1'b0;
    hold_req = 1'b0;
    tick_now = '0;
    cur_slot = '0;
    for (int i = 0; i < NTASKS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_state[i] = '0;
      tbl_susp[i] = 1'b0;
      tbl_wake[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_directed_cases();
    test_output_backpressure();
    test_random_traffic();
    test_output_backpressure();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (2 * NTASKS + 10) @(posedge clk_i);

    $display("covered %0d slot writes and %0d schedule items with random idling",
             n_writes, n_scheds);
    $display("%0d picks, %0d timeout wakes, %0d terminated slots freed",
             n_picks, n_timeouts, n_freed);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
